>>> hdl/audio_peak_rms_level_meter_unit_macros.svh
// assertion macros for the level meter unit
// no dependencies; included by files that carry concurrent assertions
`ifndef AUDIO_PEAK_RMS_LEVEL_METER_UNIT_MACROS_SVH
`define AUDIO_PEAK_RMS_LEVEL_METER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// plain property, disabled while reset is low
`define APLM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication, disabled while reset is low
`define APLM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define APLM_ASSERT(lbl, clk, rst_n, prop, msg)
`define APLM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hdl/aplm_pkg.sv
// shared types and constants for the level meter unit
// no dependencies
package aplm_pkg;

    localparam int SUM_BITS = 64;
    localparam int ALU_BITS = SUM_BITS + 1;
    localparam int THR_BITS = 23;
    localparam int CMP_BITS = 33;
    localparam int ITER_BITS = 6;

    localparam logic [THR_BITS-1:0] THR_RESET = 23'd84;

    localparam logic [1:0] CMD_ACCUM  = 2'd0;
    localparam logic [1:0] CMD_REPORT = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] VERDICT_SIGNAL  = 2'd0;
    localparam logic [1:0] VERDICT_INVALID = 2'd1;
    localparam logic [1:0] VERDICT_SILENT  = 2'd2;

    typedef struct packed {
        logic                ge;
        logic [ALU_BITS-1:0] diff;
    } t_alu_res;

endpackage

>>> hdl/aplm_cmpsub.sv
// shared compare-and-subtract unit, used by the divide and square root steps
// depends on aplm_pkg
module aplm_cmpsub
    import aplm_pkg::*;
(
    input  logic [ALU_BITS-1:0] i_a,
    input  logic [ALU_BITS-1:0] i_b,
    output t_alu_res            o_res
);

    logic [ALU_BITS:0] w_diff;

    // borrow out of the extended subtract gives a < b
    assign w_diff     = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.ge   = ~w_diff[ALU_BITS];
    assign o_res.diff = w_diff[ALU_BITS-1:0];

endmodule

>>> hdl/audio_peak_rms_level_meter_unit.sv
// channel   | handshake               | payload
// ----------+-------------------------+------------------------------------------------
// input     | i_in_valid / o_in_ready | i_cmd i_sample i_sample_invalid i_frame_start
//           |                         | i_frame_silent
// result    | o_out_valid/i_out_ready | o_peak_level o_rms_level o_frames_seen
//           |                         | o_silent_frames_seen o_invalid_samples_seen o_verdict
// config    | i_cfg_we                | i_cfg_wdata
//
// accumulate steps through capture, multiply and add; clear and unused commands finish in capture
// report runs 64 restoring divide steps and 32 square root steps, both on the
// one compare-subtract unit, plus capture and result load; just capture and load with no valid sample
// the result register frees the input side; a report waits only if the previous one is held
// synchronous active-low reset zeroes the accumulators and sets the threshold to 84
// top level of the level meter; depends on aplm_pkg, aplm_cmpsub and the macro header
`include "audio_peak_rms_level_meter_unit_macros.svh"
module audio_peak_rms_level_meter_unit
    import aplm_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 40
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [THR_BITS-1:0]    i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [1:0]             i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_sample_invalid,
    input  logic                   i_frame_start,
    input  logic                   i_frame_silent,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [SAMPLE_BITS-1:0] o_peak_level,
    output logic [SAMPLE_BITS-1:0] o_rms_level,
    output logic [COUNT_BITS-1:0]  o_frames_seen,
    output logic [COUNT_BITS-1:0]  o_silent_frames_seen,
    output logic [COUNT_BITS-1:0]  o_invalid_samples_seen,
    output logic [1:0]             o_verdict
);

    localparam logic [SUM_BITS-1:0] RMS_FULL = SUM_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [SUM_BITS-1:0] BIT_TOP  = SUM_BITS'(1) << (SUM_BITS - 2);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_ADD, S_DIV, S_SQRT, S_DONE
    } t_state;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    t_state                  r_state, n_state;
    logic [THR_BITS-1:0]     r_thr, n_thr;
    logic [SAMPLE_BITS-1:0]  r_peak, n_peak;
    logic [SUM_BITS-1:0]     r_sum, n_sum;
    logic [COUNT_BITS-1:0]   r_valid_cnt, n_valid_cnt;
    logic [COUNT_BITS-1:0]   r_inv_cnt, n_inv_cnt;
    logic [COUNT_BITS-1:0]   r_frame_cnt, n_frame_cnt;
    logic [COUNT_BITS-1:0]   r_silent_cnt, n_silent_cnt;
    logic [SAMPLE_BITS-1:0]  r_mag, n_mag;
    logic                    r_inv, n_inv;
    logic                    r_fstart, n_fstart;
    logic                    r_fsilent, n_fsilent;
    logic [SUM_BITS-1:0]     r_sq, n_sq;
    logic [ALU_BITS-1:0]     r_rem, n_rem;
    logic [SUM_BITS-1:0]     r_quo, n_quo;
    logic [SUM_BITS-1:0]     r_root, n_root;
    logic [SUM_BITS-1:0]     r_bit, n_bit;
    logic [ITER_BITS-1:0]    r_iter, n_iter;
    logic                    r_out_valid, n_out_valid;
    logic [SAMPLE_BITS-1:0]  r_o_peak, n_o_peak;
    logic [SAMPLE_BITS-1:0]  r_o_rms, n_o_rms;
    logic [COUNT_BITS-1:0]   r_o_frames, n_o_frames;
    logic [COUNT_BITS-1:0]   r_o_silent, n_o_silent;
    logic [COUNT_BITS-1:0]   r_o_inv, n_o_inv;
    logic [1:0]              r_o_verdict, n_o_verdict;

    logic [SAMPLE_BITS-1:0]   w_in_mag;
    logic [2*SAMPLE_BITS-1:0] w_prod;
    logic [SUM_BITS:0]        w_sum_ext;
    logic [ALU_BITS-1:0]      w_div_shift;
    logic [ALU_BITS-1:0]      w_divisor;
    logic [ALU_BITS-1:0]      w_alu_a, w_alu_b;
    t_alu_res                 w_alu;
    logic                     w_below_thr;

    // magnitude of the most negative code still fits unsigned in the sample width
    assign w_in_mag    = i_sample[SAMPLE_BITS-1] ? (~i_sample + SAMPLE_BITS'(1)) : i_sample;
    assign w_prod      = r_mag * r_mag;
    assign w_sum_ext   = {1'b0, r_sum} + {1'b0, r_sq};
    assign w_div_shift = {r_rem[ALU_BITS-2:0], r_quo[SUM_BITS-1]};
    assign w_divisor   = ALU_BITS'(r_valid_cnt);
    assign w_below_thr = CMP_BITS'(r_peak) < CMP_BITS'(r_thr);

    always_comb begin
        if (r_state == S_SQRT) begin
            w_alu_a = {1'b0, r_quo};
            w_alu_b = {1'b0, r_root | r_bit};
        end else begin
            w_alu_a = w_div_shift;
            w_alu_b = w_divisor;
        end
    end

    aplm_cmpsub u_cmpsub (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_res (w_alu)
    );

    always_comb begin
        n_state      = r_state;
        n_thr        = r_thr;
        n_peak       = r_peak;
        n_sum        = r_sum;
        n_valid_cnt  = r_valid_cnt;
        n_inv_cnt    = r_inv_cnt;
        n_frame_cnt  = r_frame_cnt;
        n_silent_cnt = r_silent_cnt;
        n_mag        = r_mag;
        n_inv        = r_inv;
        n_fstart     = r_fstart;
        n_fsilent    = r_fsilent;
        n_sq         = r_sq;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_root       = r_root;
        n_bit        = r_bit;
        n_iter       = r_iter;
        n_out_valid  = r_out_valid & ~i_out_ready;
        n_o_peak     = r_o_peak;
        n_o_rms      = r_o_rms;
        n_o_frames   = r_o_frames;
        n_o_silent   = r_o_silent;
        n_o_inv      = r_o_inv;
        n_o_verdict  = r_o_verdict;

        if (i_cfg_we) begin
            n_thr = i_cfg_wdata;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_cmd)
                        CMD_ACCUM: begin
                            n_mag     = w_in_mag;
                            n_inv     = i_sample_invalid;
                            n_fstart  = i_frame_start;
                            n_fsilent = i_frame_silent;
                            n_state   = S_MUL;
                        end
                        CMD_REPORT: begin
                            if (r_valid_cnt == '0) begin
                                n_root  = '0;
                                n_state = S_DONE;
                            end else begin
                                n_rem   = '0;
                                n_quo   = r_sum;
                                n_iter  = ITER_BITS'(SUM_BITS - 1);
                                n_state = S_DIV;
                            end
                        end
                        CMD_CLEAR: begin
                            n_peak       = '0;
                            n_sum        = '0;
                            n_valid_cnt  = '0;
                            n_inv_cnt    = '0;
                            n_frame_cnt  = '0;
                            n_silent_cnt = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                n_sq    = SUM_BITS'(w_prod);
                n_state = S_ADD;
            end
            S_ADD: begin
                if (r_fstart) begin
                    n_frame_cnt = sat_inc(r_frame_cnt);
                    if (r_fsilent) begin
                        n_silent_cnt = sat_inc(r_silent_cnt);
                    end
                end
                if (r_inv) begin
                    n_inv_cnt = sat_inc(r_inv_cnt);
                end else begin
                    if (r_mag > r_peak) begin
                        n_peak = r_mag;
                    end
                    n_sum       = w_sum_ext[SUM_BITS] ? '1 : w_sum_ext[SUM_BITS-1:0];
                    n_valid_cnt = sat_inc(r_valid_cnt);
                end
                n_state = S_IDLE;
            end
            S_DIV: begin
                // restoring divide, one quotient bit a cycle
                n_rem  = w_alu.ge ? w_alu.diff : w_div_shift;
                n_quo  = {r_quo[SUM_BITS-2:0], w_alu.ge};
                n_iter = r_iter - ITER_BITS'(1);
                if (r_iter == '0) begin
                    n_root  = '0;
                    n_bit   = BIT_TOP;
                    n_iter  = ITER_BITS'(SUM_BITS / 2 - 1);
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                // root and bit never overlap, so or stands in for the add
                if (w_alu.ge) begin
                    n_quo  = w_alu.diff[SUM_BITS-1:0];
                    n_root = (r_root >> 1) | r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit  = r_bit >> 2;
                n_iter = r_iter - ITER_BITS'(1);
                if (r_iter == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_peak    = r_peak;
                    n_o_rms     = (r_root > RMS_FULL) ? RMS_FULL[SAMPLE_BITS-1:0]
                                                      : r_root[SAMPLE_BITS-1:0];
                    n_o_frames  = r_frame_cnt;
                    n_o_silent  = r_silent_cnt;
                    n_o_inv     = r_inv_cnt;
                    if (r_inv_cnt != '0) begin
                        n_o_verdict = VERDICT_INVALID;
                    end else if (r_frame_cnt == '0 || w_below_thr) begin
                        n_o_verdict = VERDICT_SILENT;
                    end else begin
                        n_o_verdict = VERDICT_SIGNAL;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_thr        <= THR_RESET;
            r_peak       <= '0;
            r_sum        <= '0;
            r_valid_cnt  <= '0;
            r_inv_cnt    <= '0;
            r_frame_cnt  <= '0;
            r_silent_cnt <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_thr        <= n_thr;
            r_peak       <= n_peak;
            r_sum        <= n_sum;
            r_valid_cnt  <= n_valid_cnt;
            r_inv_cnt    <= n_inv_cnt;
            r_frame_cnt  <= n_frame_cnt;
            r_silent_cnt <= n_silent_cnt;
            r_out_valid  <= n_out_valid;
        end
        r_mag       <= n_mag;
        r_inv       <= n_inv;
        r_fstart    <= n_fstart;
        r_fsilent   <= n_fsilent;
        r_sq        <= n_sq;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_root      <= n_root;
        r_bit       <= n_bit;
        r_iter      <= n_iter;
        r_o_peak    <= n_o_peak;
        r_o_rms     <= n_o_rms;
        r_o_frames  <= n_o_frames;
        r_o_silent  <= n_o_silent;
        r_o_inv     <= n_o_inv;
        r_o_verdict <= n_o_verdict;
    end

    assign o_in_ready             = (r_state == S_IDLE);
    assign o_out_valid            = r_out_valid;
    assign o_peak_level           = r_o_peak;
    assign o_rms_level            = r_o_rms;
    assign o_frames_seen          = r_o_frames;
    assign o_silent_frames_seen   = r_o_silent;
    assign o_invalid_samples_seen = r_o_inv;
    assign o_verdict              = r_o_verdict;

    `APLM_ASSERT_IMPL(a_rem_below_divisor, i_clk, i_rst_n, r_state == S_DIV, r_rem < w_divisor, "divide remainder not below divisor")
    `APLM_ASSERT_IMPL(a_root_bit_disjoint, i_clk, i_rst_n, r_state == S_SQRT, (r_root & r_bit) == '0, "square root partial overlaps bit")
    `APLM_ASSERT(a_peak_in_range, i_clk, i_rst_n, SUM_BITS'(r_peak) <= RMS_FULL, "peak above full scale")
    `APLM_ASSERT_IMPL(a_result_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_DONE, "result raised outside result load")

endmodule
